@@ hdl/rex_pkg.sv @@
// Shared types, constants and small decode functions for the Reduce expander.
// Used by rex_ctrl, rex_dp and reduce_expander; depends on nothing.
package rex_pkg;

   localparam int WIN_BITS  = 14;
   localparam int SLOT_BITS = 6;
   localparam int CNT_DEPTH = 256;
   localparam int TAB_DEPTH = 256 * (1 << SLOT_BITS);
   localparam int WIN_DEPTH = 1 << WIN_BITS;

   localparam logic [7:0] ESC_CODE = 8'd144;
   localparam logic [8:0] OUT_CAP  = 9'd400;

   localparam logic CSR_USIZE  = 1'b0;
   localparam logic CSR_FACTOR = 1'b1;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_FLAG = 2'd1,
      ESC_LEN  = 2'd2,
      ESC_DIST = 2'd3
   } esc_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       entry_start;
   } req_word_type;

   typedef struct packed {
      logic [63:0] out_bytes;
      logic [3:0]  out_count;
      logic        run_last;
      logic        entry_done;
   } rsp_word_type;

   typedef struct packed {
      logic take;
      logic hdr_step;
      logic cnt_rd;
      logic sym_lit;
      logic tab_rd;
      logic sym_tab;
      logic win_rd;
      logic copy_emit;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic copy_pend;
      logic cap_hit;
      logic loading;
      logic rem_zero;
      logic hdr_stall;
      logic dec_stall;
      logic dec_lit;
      logic pk_busy;
      logic acc_empty;
      logic out_busy;
   } dp_status_type;

   function automatic logic [7:0] len_mask(input logic [2:0] f);
      logic [7:0] m;
      unique case (f)
         3'd1:    m = 8'h7f;
         3'd2:    m = 8'h3f;
         3'd3:    m = 8'h1f;
         3'd4:    m = 8'h0f;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   function automatic logic [2:0] dist_shift(input logic [2:0] f);
      logic [2:0] s;
      unique case (f)
         3'd1:    s = 3'd7;
         3'd2:    s = 3'd6;
         3'd3:    s = 3'd5;
         3'd4:    s = 3'd4;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic logic [3:0] dist_mask(input logic [2:0] f);
      logic [3:0] m;
      unique case (f)
         3'd1:    m = 4'h1;
         3'd2:    m = 4'h3;
         3'd3:    m = 4'h7;
         3'd4:    m = 4'hf;
         default: m = 4'h0;
      endcase
      return m;
   endfunction

   // index width for a follower set of sl entries (sl >= 1)
   function automatic logic [2:0] index_bits(input logic [5:0] sl);
      logic [2:0] nb;
      if (sl <= 6'd2)       nb = 3'd1;
      else if (sl <= 6'd4)  nb = 3'd2;
      else if (sl <= 6'd8)  nb = 3'd3;
      else if (sl <= 6'd16) nb = 3'd4;
      else if (sl <= 6'd32) nb = 3'd5;
      else                  nb = 3'd6;
      return nb;
   endfunction

   function automatic logic [5:0] index_mask(input logic [2:0] nb);
      logic [5:0] m;
      unique case (nb)
         3'd1:    m = 6'h01;
         3'd2:    m = 6'h03;
         3'd3:    m = 6'h07;
         3'd4:    m = 6'h0f;
         3'd5:    m = 6'h1f;
         3'd6:    m = 6'h3f;
         default: m = 6'h00;
      endcase
      return m;
   endfunction

endpackage

@@ hdl/reduce_expander.sv @@
// Top level of the ZIP Reduce expander: sequencer plus datapath.
// Depends on rex_pkg, rex_ctrl, rex_dp (and rex_ram below it).
//
//  port group | direction | handshake            | payload
//  req_       | in        | req_valid/req_ready  | req_word (packed_byte, entry_start)
//  rsp_       | out       | rsp_valid/rsp_ready  | rsp_word (out_bytes, out_count, ...)
//  csr_       | in        | csr_we               | csr_index, csr_wdata
//
// One input word is taken, then header fields, symbols (a registered count RAM read,
// plus a follower RAM read for a non-literal) and copied bytes (a window RAM read)
// are stepped, and the result is flushed; a symbol short of bits ends the step early.
// Reset is synchronous; no RAM clearing pass is run.
// A full packer or a final flush with an untaken result waits for rsp_ready.
module reduce_expander (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rex_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rex_pkg::rsp_word_type rsp_word,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [31:0]           csr_wdata
);

   rex_pkg::dp_cmd_type    cmd;
   rex_pkg::dp_status_type status;

   rex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rex_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

@@ hdl/rex_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rex_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rex_ctrl.sv @@
// Sequencer for the Reduce expander: steps header loads, symbol decodes,
// copies and result flushes. Depends on rex_pkg.
module rex_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rex_pkg::dp_status_type status,
   output rex_pkg::dp_cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RUN  = 6'b000010,
      ST_SEL  = 6'b000100,
      ST_TAB  = 6'b001000,
      ST_CPW  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.copy_pend) begin
               if (status.cap_hit) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.win_rd = 1'b1;
                  state_in   = ST_CPW;
               end
            end else if (status.loading) begin
               if (status.hdr_stall) begin
                  state_in = ST_FIN;
               end else begin
                  cmd.hdr_step = 1'b1;
               end
            end else if (status.rem_zero || status.cap_hit) begin
               state_in = ST_FIN;
            end else begin
               cmd.cnt_rd = 1'b1;
               state_in   = ST_SEL;
            end
         end
         ST_SEL: begin
            if (status.dec_stall) begin
               state_in = ST_FIN;
            end else if (!status.dec_lit) begin
               cmd.tab_rd = 1'b1;
               state_in   = ST_TAB;
            end else if (!status.pk_busy) begin
               cmd.sym_lit = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_TAB: begin
            if (!status.pk_busy) begin
               cmd.sym_tab = 1'b1;
               state_in    = ST_RUN;
            end
         end
         ST_CPW: begin
            if (!status.pk_busy) begin
               cmd.copy_emit = 1'b1;
               state_in      = ST_RUN;
            end
         end
         ST_FIN: begin
            if (status.acc_empty) begin
               state_in = ST_IDLE;
            end else if (!status.out_busy) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/rex_dp.sv @@
// Datapath for the Reduce expander: bit buffer, follower and window RAMs,
// escape decoding, copy engine, byte packer and result register.
// Depends on rex_pkg and rex_ram.
module rex_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rex_pkg::dp_cmd_type    cmd,
   output rex_pkg::dp_status_type status,
   input  rex_pkg::req_word_type  req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rex_pkg::rsp_word_type  rsp_word,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [31:0]            csr_wdata
);

   logic [31:0] usize_ff;
   logic [2:0]  factor_ff;

   logic [31:0] buf_ff, buf_in;
   logic [5:0]  bits_ff, bits_in;
   logic        loading_ff, loading_in;
   logic [7:0]  slot_ff, slot_in;
   logic [5:0]  fill_ff, fill_in;
   logic        counted_ff, counted_in;
   logic [5:0]  hcount_ff, hcount_in;
   logic [rex_pkg::WIN_BITS-1:0] pos_ff, pos_in;
   logic        wrapped_ff, wrapped_in;
   logic [7:0]  prev_ff, prev_in;
   rex_pkg::esc_type esc_ff, esc_in;
   logic [7:0]  escval_ff, escval_in;
   logic [8:0]  clen_ff, clen_in;
   logic [9:0]  cleft_ff, cleft_in;
   logic [rex_pkg::WIN_BITS-1:0] src_ff, src_in;
   logic [31:0] rem_ff, rem_in;
   logic [8:0]  outn_ff, outn_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  acc_cnt_ff, acc_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rex_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [5:0]  cnt_rdata;
   logic [7:0]  tab_rdata;
   logic [7:0]  win_rdata;

   logic        cnt_we, tab_we;
   logic [7:0]  cnt_waddr;
   logic [13:0] tab_waddr;
   logic [7:0]  tab_wdata;
   logic [13:0] tab_raddr;

   logic [2:0]  nb;
   logic [5:0]  lit_len;
   logic [7:0]  lit_sym;
   logic [7:0]  sym;
   logic        sym_go;
   logic        emit_en;
   logic [7:0]  emit_val;
   logic [7:0]  copy_val;
   logic        dec_en;
   logic [9:0]  dec_amt;
   logic [6:0]  fill_next;
   logic [7:0]  lmask;
   logic [3:0]  dist_hi;
   logic [12:0] back_dist;
   logic        done;

   always_ff @(posedge clock) begin
      if (reset) begin
         usize_ff  <= '0;
         factor_ff <= 3'd1;
      end else if (csr_we) begin
         if (csr_index == rex_pkg::CSR_USIZE) begin
            usize_ff <= csr_wdata;
         end else begin
            factor_ff <= csr_wdata[2:0];
         end
      end
   end

   assign nb      = rex_pkg::index_bits(cnt_rdata);
   assign lit_len = (cnt_rdata == 6'd0) ? 6'd8 : 6'd9;
   assign lit_sym = (cnt_rdata == 6'd0) ? buf_ff[7:0] : buf_ff[8:1];
   assign tab_raddr = {prev_ff, buf_ff[6:1] & rex_pkg::index_mask(nb)};
   assign copy_val = (!wrapped_ff && (src_ff >= pos_ff)) ? 8'd0 : win_rdata;
   assign lmask    = rex_pkg::len_mask(factor_ff);
   assign dist_hi  = 4'((escval_ff >> rex_pkg::dist_shift(factor_ff)))
                     & rex_pkg::dist_mask(factor_ff);
   assign fill_next = {1'b0, fill_ff} + 7'd1;
   assign done = !loading_ff && (rem_ff == 32'd0) && (cleft_ff == 10'd0);

   always_comb begin
      buf_in      = buf_ff;
      bits_in     = bits_ff;
      loading_in  = loading_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      counted_in  = counted_ff;
      hcount_in   = hcount_ff;
      pos_in      = pos_ff;
      wrapped_in  = wrapped_ff;
      prev_in     = prev_ff;
      esc_in      = esc_ff;
      escval_in   = escval_ff;
      clen_in     = clen_ff;
      cleft_in    = cleft_ff;
      src_in      = src_ff;
      rem_in      = rem_ff;
      outn_in     = outn_ff;
      acc_in      = acc_ff;
      acc_cnt_in  = acc_cnt_ff;
      rsp_word_in = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cnt_we      = 1'b0;
      cnt_waddr   = slot_ff;
      tab_we      = 1'b0;
      tab_waddr   = {slot_ff, fill_ff};
      tab_wdata   = buf_ff[7:0];
      sym_go      = cmd.sym_lit || cmd.sym_tab;
      sym         = cmd.sym_tab ? tab_rdata : lit_sym;
      emit_en     = 1'b0;
      emit_val    = sym;
      dec_en      = 1'b0;
      dec_amt     = 10'd1;
      back_dist   = '0;

      if (cmd.take) begin
         if (req_word.entry_start) begin
            buf_in     = '0;
            bits_in    = '0;
            loading_in = 1'b1;
            slot_in    = 8'hff;
            fill_in    = '0;
            counted_in = 1'b0;
            pos_in     = '0;
            wrapped_in = 1'b0;
            prev_in    = '0;
            esc_in     = rex_pkg::ESC_NONE;
            escval_in  = '0;
            clen_in    = '0;
            cleft_in   = '0;
            src_in     = '0;
            rem_in     = usize_ff;
         end
         if ((loading_in || (rem_in != 32'd0)) && (bits_in <= 6'd24)) begin
            buf_in  = buf_in | ({24'd0, req_word.packed_byte} << bits_in);
            bits_in = bits_in + 6'd8;
         end
         outn_in = '0;
      end

      if (cmd.hdr_step) begin
         if (!counted_ff) begin
            cnt_we     = 1'b1;
            hcount_in  = buf_ff[5:0];
            buf_in     = buf_ff >> 6;
            bits_in    = bits_ff - 6'd6;
            fill_in    = '0;
            counted_in = (buf_ff[5:0] != 6'd0);
         end else begin
            tab_we     = 1'b1;
            buf_in     = buf_ff >> 8;
            bits_in    = bits_ff - 6'd8;
            fill_in    = fill_next[5:0];
            counted_in = (fill_next < {1'b0, hcount_ff});
         end
         if (!counted_in) begin
            if (slot_ff == 8'd0) begin
               loading_in = 1'b0;
            end else begin
               slot_in = slot_ff - 8'd1;
            end
         end
      end

      if (cmd.sym_lit) begin
         buf_in  = buf_ff >> lit_len;
         bits_in = bits_ff - lit_len;
      end

      if (cmd.tab_rd) begin
         buf_in  = buf_ff >> ({3'd0, nb} + 6'd1);
         bits_in = bits_ff - ({3'd0, nb} + 6'd1);
      end

      if (sym_go) begin
         prev_in = sym;
         case (esc_ff)
            rex_pkg::ESC_NONE: begin
               if (sym == rex_pkg::ESC_CODE) begin
                  esc_in = rex_pkg::ESC_FLAG;
               end else begin
                  emit_en = 1'b1;
                  dec_en  = 1'b1;
               end
            end
            rex_pkg::ESC_FLAG: begin
               if (sym != 8'd0) begin
                  escval_in = sym;
                  clen_in   = {1'b0, sym & lmask};
                  esc_in    = ((sym & lmask) == lmask) ? rex_pkg::ESC_LEN
                                                       : rex_pkg::ESC_DIST;
               end else begin
                  emit_en  = 1'b1;
                  emit_val = rex_pkg::ESC_CODE;
                  dec_en   = 1'b1;
                  esc_in   = rex_pkg::ESC_NONE;
               end
            end
            rex_pkg::ESC_LEN: begin
               clen_in = clen_ff + {1'b0, sym};
               esc_in  = rex_pkg::ESC_DIST;
            end
            default: begin
               back_dist = {1'b0, dist_hi, sym} + 13'd1;
               cleft_in  = {1'b0, clen_ff} + 10'd3;
               src_in    = pos_ff - {1'b0, back_dist};
               dec_en    = 1'b1;
               dec_amt   = cleft_in;
               esc_in    = rex_pkg::ESC_NONE;
            end
         endcase
      end

      if (cmd.copy_emit) begin
         emit_en  = 1'b1;
         emit_val = copy_val;
         src_in   = src_ff + 1'b1;
         cleft_in = cleft_ff - 10'd1;
      end

      if (dec_en) begin
         rem_in = ({22'd0, dec_amt} >= rem_ff) ? 32'd0 : rem_ff - {22'd0, dec_amt};
      end

      if (emit_en) begin
         pos_in  = pos_ff + 1'b1;
         if (pos_in == '0) begin
            wrapped_in = 1'b1;
         end
         outn_in = outn_ff + 9'd1;
         if (acc_cnt_ff == 4'd8) begin
            rsp_word_in.out_bytes  = acc_ff;
            rsp_word_in.out_count  = 4'd8;
            rsp_word_in.run_last   = 1'b0;
            rsp_word_in.entry_done = 1'b0;
            rsp_valid_in           = 1'b1;
            acc_in     = {56'd0, emit_val};
            acc_cnt_in = 4'd1;
         end else begin
            acc_in[{acc_cnt_ff[2:0], 3'b000} +: 8] = emit_val;
            acc_cnt_in = acc_cnt_ff + 4'd1;
         end
      end

      if (cmd.flush) begin
         rsp_word_in.out_bytes  = acc_ff;
         rsp_word_in.out_count  = acc_cnt_ff;
         rsp_word_in.run_last   = 1'b1;
         rsp_word_in.entry_done = done;
         rsp_valid_in           = 1'b1;
         acc_in     = '0;
         acc_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff       <= '0;
         bits_ff      <= '0;
         loading_ff   <= 1'b1;
         slot_ff      <= 8'hff;
         fill_ff      <= '0;
         counted_ff   <= 1'b0;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
         prev_ff      <= '0;
         esc_ff       <= rex_pkg::ESC_NONE;
         escval_ff    <= '0;
         clen_ff      <= '0;
         cleft_ff     <= '0;
         src_ff       <= '0;
         rem_ff       <= '0;
         outn_ff      <= '0;
         acc_ff       <= '0;
         acc_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         buf_ff       <= buf_in;
         bits_ff      <= bits_in;
         loading_ff   <= loading_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         counted_ff   <= counted_in;
         pos_ff       <= pos_in;
         wrapped_ff   <= wrapped_in;
         prev_ff      <= prev_in;
         esc_ff       <= esc_in;
         escval_ff    <= escval_in;
         clen_ff      <= clen_in;
         cleft_ff     <= cleft_in;
         src_ff       <= src_in;
         rem_ff       <= rem_in;
         outn_ff      <= outn_in;
         acc_ff       <= acc_in;
         acc_cnt_ff   <= acc_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hcount_ff   <= hcount_in;
      rsp_word_ff <= rsp_word_in;
   end

   rex_ram #(.WIDTH(6), .DEPTH(rex_pkg::CNT_DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (buf_ff[5:0]),
      .rd_en   (cmd.cnt_rd),
      .rd_addr (prev_ff),
      .rd_data (cnt_rdata)
   );

   rex_ram #(.WIDTH(8), .DEPTH(rex_pkg::TAB_DEPTH)) u_follow_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_en   (cmd.tab_rd),
      .rd_addr (tab_raddr),
      .rd_data (tab_rdata)
   );

   rex_ram #(.WIDTH(8), .DEPTH(rex_pkg::WIN_DEPTH)) u_window_ram (
      .clock   (clock),
      .wr_en   (emit_en),
      .wr_addr (pos_ff),
      .wr_data (emit_val),
      .rd_en   (cmd.win_rd),
      .rd_addr (src_ff),
      .rd_data (win_rdata)
   );

   always_comb begin
      status.copy_pend = (cleft_ff != 10'd0);
      status.cap_hit   = (outn_ff >= rex_pkg::OUT_CAP);
      status.loading   = loading_ff;
      status.rem_zero  = (rem_ff == 32'd0);
      status.hdr_stall = counted_ff ? (bits_ff < 6'd8) : (bits_ff < 6'd6);
      if (cnt_rdata == 6'd0) begin
         status.dec_stall = (bits_ff < 6'd8);
      end else if (bits_ff < 6'd1) begin
         status.dec_stall = 1'b1;
      end else if (buf_ff[0]) begin
         status.dec_stall = (bits_ff < 6'd9);
      end else begin
         status.dec_stall = (bits_ff < ({3'd0, nb} + 6'd1));
      end
      status.dec_lit   = (cnt_rdata == 6'd0) || buf_ff[0];
      status.pk_busy   = (acc_cnt_ff == 4'd8) && rsp_valid_ff;
      status.acc_empty = (acc_cnt_ff == 4'd0);
      status.out_busy  = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= 6'd32) else $error("bit buffer overfilled");

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      outn_ff <= rex_pkg::OUT_CAP) else $error("step byte count past cap");

   a_copy_after_hdr: assert property (@(posedge clock) disable iff (reset)
      (cleft_ff != 10'd0) |-> !loading_ff) else $error("copy during header");

   a_flush_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (rsp_valid_ff && rsp_word_ff.run_last))
      else $error("flush lost");

endmodule
